// ===== design/xvls_pkg.sv =====
`default_nettype none
package xvls_pkg;

    localparam int COORD_W     = 16;
    localparam int GAIN_W      = 15;
    localparam int CNT_W       = 7;
    localparam int FRAC_BITS   = 14;
    localparam int MAX_SAMPLES = 64;
    localparam int PROD_W      = COORD_W + GAIN_W;
    localparam int SHIFT_W     = PROD_W - FRAC_BITS;
    localparam int DIV_STEPS   = COORD_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN  = 2'd2;

    localparam logic [CNT_W-1:0]  RST_SAMPLES = CNT_W'(20);
    localparam logic [GAIN_W-1:0] RST_X_GAIN  = GAIN_W'(30000);
    localparam logic [GAIN_W-1:0] RST_Y_GAIN  = GAIN_W'(16000);

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_PUSH
    } t_front_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic                      neg_x;
        logic                      neg_y;
        logic [COORD_W-1:0]        qx;
        logic [COORD_W-1:0]        qy;
        logic [CNT_W-1:0]          rx;
        logic [CNT_W-1:0]          ry;
        logic [CNT_W-1:0]          n;
    } t_seg;

    // floor shift by FRAC_BITS, then clamp to signed COORD_W
    function automatic logic signed [COORD_W-1:0] scale_sat(
        input logic signed [PROD_W-1:0] p
    );
        logic [SHIFT_W-1:0]        s;
        logic signed [COORD_W-1:0] res;
        s = p[PROD_W-1:FRAC_BITS];
        if (!s[SHIFT_W-1] && (|s[SHIFT_W-2:COORD_W-1])) begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (s[SHIFT_W-1] && !(&s[SHIFT_W-2:COORD_W-1])) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = s[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== design/xvls_in_if.sv =====
`default_nettype none
interface xvls_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [xvls_pkg::COORD_W-1:0] start_x;
    logic signed [xvls_pkg::COORD_W-1:0] start_y;
    logic signed [xvls_pkg::COORD_W-1:0] end_x;
    logic signed [xvls_pkg::COORD_W-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface
`default_nettype wire

// ===== design/xvls_out_if.sv =====
`default_nettype none
interface xvls_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [xvls_pkg::COORD_W-1:0] defl_x;
    logic signed [xvls_pkg::COORD_W-1:0] defl_y;
    logic                               last;

    modport source (output valid, defl_x, defl_y, last, input ready);
    modport sink   (input valid, defl_x, defl_y, last, output ready);
endinterface
`default_nettype wire

// ===== design/xvls_div.sv =====
`default_nettype none
// restoring divider, one quotient bit per step
module xvls_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_load,
    input  wire logic                          i_step,
    input  wire logic [xvls_pkg::COORD_W-1:0]  i_dividend,
    input  wire logic [xvls_pkg::CNT_W-1:0]    i_divisor,
    output logic      [xvls_pkg::COORD_W-1:0]  o_quotient,
    output logic      [xvls_pkg::CNT_W-1:0]    o_remainder
);
    logic [xvls_pkg::COORD_W-1:0] r_quo, n_quo;
    logic [xvls_pkg::CNT_W-1:0]   r_rem, n_rem;
    logic [xvls_pkg::CNT_W-1:0]   r_div;
    logic [xvls_pkg::CNT_W:0]     trial;
    logic [xvls_pkg::CNT_W:0]     diff;
    logic                         ge;

    always_comb begin
        trial = {r_rem, r_quo[xvls_pkg::COORD_W-1]};
        ge    = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
        n_rem = ge ? diff[xvls_pkg::CNT_W-1:0] : trial[xvls_pkg::CNT_W-1:0];
        n_quo = {r_quo[xvls_pkg::COORD_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (i_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule
`default_nettype wire

// ===== design/xvls_front.sv =====
`default_nettype none
// accepts a segment, computes |delta|/n per axis
module xvls_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    xvls_in_if.sink                          i_in,
    input  wire logic [xvls_pkg::CNT_W-1:0]  i_samples_per_line,
    input  wire logic                        i_full,
    output logic                             o_push,
    output xvls_pkg::t_seg                   o_seg
);
    xvls_pkg::t_front_state r_state, n_state;
    logic [xvls_pkg::STEP_W-1:0]  r_step;
    logic signed [xvls_pkg::COORD_W-1:0] r_sx, r_sy;
    logic                         r_neg_x, r_neg_y;
    logic [xvls_pkg::CNT_W-1:0]   r_n;
    logic [xvls_pkg::CNT_W-1:0]   n_clamped;
    logic [xvls_pkg::COORD_W:0]   dx, dy, dx_neg, dy_neg;
    logic [xvls_pkg::COORD_W-1:0] abs_x, abs_y;
    logic                         accept;
    logic                         div_step;
    logic                         step_last;
    logic [xvls_pkg::COORD_W-1:0] qx, qy;
    logic [xvls_pkg::CNT_W-1:0]   rx, ry;

    always_comb begin
        if (i_samples_per_line == '0) begin
            n_clamped = xvls_pkg::CNT_W'(1);
        end else if (i_samples_per_line > xvls_pkg::CNT_W'(xvls_pkg::MAX_SAMPLES)) begin
            n_clamped = xvls_pkg::CNT_W'(xvls_pkg::MAX_SAMPLES);
        end else begin
            n_clamped = i_samples_per_line;
        end
        dx     = {i_in.end_x[xvls_pkg::COORD_W-1], i_in.end_x}
               - {i_in.start_x[xvls_pkg::COORD_W-1], i_in.start_x};
        dy     = {i_in.end_y[xvls_pkg::COORD_W-1], i_in.end_y}
               - {i_in.start_y[xvls_pkg::COORD_W-1], i_in.start_y};
        dx_neg = -dx;
        dy_neg = -dy;
        abs_x  = dx[xvls_pkg::COORD_W] ? dx_neg[xvls_pkg::COORD_W-1:0]
                                       : dx[xvls_pkg::COORD_W-1:0];
        abs_y  = dy[xvls_pkg::COORD_W] ? dy_neg[xvls_pkg::COORD_W-1:0]
                                       : dy[xvls_pkg::COORD_W-1:0];
    end

    // next state
    always_comb begin
        step_last = r_step == xvls_pkg::STEP_W'(xvls_pkg::DIV_STEPS - 1);
        n_state   = r_state;
        case (r_state)
            xvls_pkg::FS_IDLE: begin
                if (i_in.valid) n_state = xvls_pkg::FS_DIV;
            end
            xvls_pkg::FS_DIV: begin
                if (step_last) n_state = xvls_pkg::FS_PUSH;
            end
            xvls_pkg::FS_PUSH: begin
                if (!i_full) n_state = xvls_pkg::FS_IDLE;
            end
            default: n_state = xvls_pkg::FS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready = 1'b0;
        div_step   = 1'b0;
        o_push     = 1'b0;
        case (r_state)
            xvls_pkg::FS_IDLE: i_in.ready = 1'b1;
            xvls_pkg::FS_DIV:  div_step   = 1'b1;
            xvls_pkg::FS_PUSH: o_push     = !i_full;
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
        accept = i_in.valid && i_in.ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xvls_pkg::FS_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_step <= '0;
            end else if (div_step) begin
                r_step <= r_step + xvls_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sx    <= i_in.start_x;
            r_sy    <= i_in.start_y;
            r_neg_x <= dx[xvls_pkg::COORD_W];
            r_neg_y <= dy[xvls_pkg::COORD_W];
            r_n     <= n_clamped;
        end
    end

    xvls_div u_div_x (
        .i_clk       (i_clk),
        .i_load      (accept),
        .i_step      (div_step),
        .i_dividend  (abs_x),
        .i_divisor   (n_clamped),
        .o_quotient  (qx),
        .o_remainder (rx)
    );

    xvls_div u_div_y (
        .i_clk       (i_clk),
        .i_load      (accept),
        .i_step      (div_step),
        .i_dividend  (abs_y),
        .i_divisor   (n_clamped),
        .o_quotient  (qy),
        .o_remainder (ry)
    );

    always_comb begin
        o_seg.sx    = r_sx;
        o_seg.sy    = r_sy;
        o_seg.neg_x = r_neg_x;
        o_seg.neg_y = r_neg_y;
        o_seg.qx    = qx;
        o_seg.qy    = qy;
        o_seg.rx    = rx;
        o_seg.ry    = ry;
        o_seg.n     = r_n;
    end
endmodule
`default_nettype wire

// ===== design/xvls_fifo.sv =====
`default_nettype none
module xvls_fifo (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire xvls_pkg::t_seg i_data,
    input  wire logic   i_pop,
    output xvls_pkg::t_seg o_data,
    output logic        o_full,
    output logic        o_empty
);
    xvls_pkg::t_seg r_mem [xvls_pkg::FIFO_DEPTH];
    logic [xvls_pkg::FIFO_PTR_W-1:0] r_wp, r_rp;
    logic [xvls_pkg::FIFO_PTR_W:0]   r_cnt;

    assign o_full  = r_cnt == (xvls_pkg::FIFO_PTR_W+1)'(xvls_pkg::FIFO_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + xvls_pkg::FIFO_PTR_W'(1);
            if (i_pop)  r_rp <= r_rp + xvls_pkg::FIFO_PTR_W'(1);
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (xvls_pkg::FIFO_PTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (xvls_pkg::FIFO_PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

// ===== design/xvls_back.sv =====
`default_nettype none
// steps quotient/remainder per sample, then scale and saturate
module xvls_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_empty,
    input  wire xvls_pkg::t_seg               i_seg,
    output logic                              o_pop,
    output logic                              o_busy,
    input  wire logic [xvls_pkg::GAIN_W-1:0]  i_x_gain,
    input  wire logic [xvls_pkg::GAIN_W-1:0]  i_y_gain,
    xvls_out_if.source                        o_out
);
    localparam int CW = xvls_pkg::COORD_W;
    localparam int NW = xvls_pkg::CNT_W;
    localparam int PW = xvls_pkg::PROD_W;

    xvls_pkg::t_seg  r_seg;
    logic            r_busy;
    logic [NW-1:0]   r_idx, idx_inc;
    logic [CW-1:0]   r_qx, r_qy;
    logic [NW-1:0]   r_rx, r_ry;
    logic            advance, gen, gen_last;
    logic [NW:0]     rx_sum, ry_sum, rx_sub, ry_sub;
    logic            wrap_x, wrap_y;
    logic [CW:0]     off_x, off_y, cx_sum, cy_sum;
    logic signed [CW-1:0] cx, cy;

    logic                 r_s1_v, r_s1_last;
    logic signed [CW-1:0] r_s1_cx, r_s1_cy;
    logic                 r_s2_v, r_s2_last;
    logic signed [PW-1:0] r_s2_px, r_s2_py;
    logic signed [PW-1:0] prod_x, prod_y;
    logic                 r_o_valid, r_o_last;
    logic signed [CW-1:0] r_o_x, r_o_y;

    always_comb begin
        advance  = !r_o_valid || o_out.ready;
        gen      = r_busy && advance;
        o_pop    = !r_busy && !i_empty;
        idx_inc  = r_idx + NW'(1);
        gen_last = idx_inc == r_seg.n;

        off_x  = r_seg.neg_x ? -{1'b0, r_qx} : {1'b0, r_qx};
        off_y  = r_seg.neg_y ? -{1'b0, r_qy} : {1'b0, r_qy};
        cx_sum = {r_seg.sx[CW-1], r_seg.sx} + off_x;
        cy_sum = {r_seg.sy[CW-1], r_seg.sy} + off_y;
        cx     = cx_sum[CW-1:0];
        cy     = cy_sum[CW-1:0];

        rx_sum = {1'b0, r_rx} + {1'b0, r_seg.rx};
        ry_sum = {1'b0, r_ry} + {1'b0, r_seg.ry};
        wrap_x = rx_sum >= {1'b0, r_seg.n};
        wrap_y = ry_sum >= {1'b0, r_seg.n};
        rx_sub = rx_sum - {1'b0, r_seg.n};
        ry_sub = ry_sum - {1'b0, r_seg.n};

        prod_x = PW'(r_s1_cx) * PW'($signed({1'b0, i_x_gain}));
        prod_y = PW'(r_s1_cy) * PW'($signed({1'b0, i_y_gain}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (gen && gen_last) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_s1_v    <= gen;
                r_s2_v    <= r_s1_v;
                r_o_valid <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_seg <= i_seg;
            r_idx <= '0;
            r_qx  <= '0;
            r_qy  <= '0;
            r_rx  <= '0;
            r_ry  <= '0;
        end else if (gen) begin
            r_idx <= idx_inc;
            r_qx  <= r_qx + r_seg.qx + CW'(wrap_x);
            r_qy  <= r_qy + r_seg.qy + CW'(wrap_y);
            r_rx  <= wrap_x ? rx_sub[NW-1:0] : rx_sum[NW-1:0];
            r_ry  <= wrap_y ? ry_sub[NW-1:0] : ry_sum[NW-1:0];
        end
        if (advance) begin
            r_s1_cx   <= cx;
            r_s1_cy   <= cy;
            r_s1_last <= gen_last;
            r_s2_px   <= prod_x;
            r_s2_py   <= prod_y;
            r_s2_last <= r_s1_last;
            r_o_x     <= xvls_pkg::scale_sat(r_s2_px);
            r_o_y     <= xvls_pkg::scale_sat(r_s2_py);
            r_o_last  <= r_s2_last;
        end
    end

    assign o_busy       = r_busy;
    assign o_out.valid  = r_o_valid;
    assign o_out.defl_x = r_o_x;
    assign o_out.defl_y = r_o_y;
    assign o_out.last   = r_o_last;
endmodule
`default_nettype wire

// ===== design/xy_vector_line_sampler_core.sv =====
// Flow: a segment is taken, divided in FS_DIV, then queued once the queue has room;
//   its samples pass stages s1, s2 and the output register once the back end pops it.
// Throughput: the front end takes no new segment until its last is queued; unstalled,
//   the back end emits one sample per cycle, n per segment (n = clamped count).
// Reset: synchronous, active low; queue and pipeline empty, registers 20/30000/16000.
`default_nettype none
module xy_vector_line_sampler_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    xvls_in_if.sink                              i_in,
    xvls_out_if.source                           o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [xvls_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [xvls_pkg::GAIN_W-1:0]     i_cfg_data
);
    logic [xvls_pkg::CNT_W-1:0]  r_samples_per_line;
    logic [xvls_pkg::GAIN_W-1:0] r_x_gain, r_y_gain;
    xvls_pkg::t_seg push_seg, pop_seg;
    logic push, pop, full, empty, busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples_per_line <= xvls_pkg::RST_SAMPLES;
            r_x_gain           <= xvls_pkg::RST_X_GAIN;
            r_y_gain           <= xvls_pkg::RST_Y_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                xvls_pkg::CFG_SAMPLES: r_samples_per_line <= i_cfg_data[xvls_pkg::CNT_W-1:0];
                xvls_pkg::CFG_X_GAIN:  r_x_gain <= i_cfg_data;
                xvls_pkg::CFG_Y_GAIN:  r_y_gain <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    xvls_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in               (i_in),
        .i_samples_per_line (r_samples_per_line),
        .i_full             (full),
        .o_push             (push),
        .o_seg              (push_seg)
    );

    xvls_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_seg),
        .i_pop   (pop),
        .o_data  (pop_seg),
        .o_full  (full),
        .o_empty (empty)
    );

    xvls_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_seg    (pop_seg),
        .o_pop    (pop),
        .o_busy   (busy),
        .i_x_gain (r_x_gain),
        .i_y_gain (r_y_gain),
        .o_out    (o_out)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full) else $error("request queued into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("request taken from an empty queue");

    a_pop_starts_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> busy) else $error("back end idle after taking a request");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !busy) else $error("request taken while back end busy");
endmodule
`default_nettype wire

// ===== tb/xvls_sample_checker.sv =====
`timescale 1ns / 100ps
module xvls_sample_checker
    import xvls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    xvls_in_if                   seg_mon,
    xvls_out_if                  smp_mon,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } t_sample;

    t_sample           sample_q[$];
    logic [CNT_W-1:0]  cfg_count;
    logic [GAIN_W-1:0] cfg_x_gain;
    logic [GAIN_W-1:0] cfg_y_gain;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic longint lerp(input logic signed [COORD_W-1:0] a,
                                    input logic signed [COORD_W-1:0] b,
                                    input longint step, input longint count);
        return longint'(a) + ((longint'(b) - longint'(a)) * step) / count;
    endfunction

    // floor shift of coord * gain, clamped to 16 bits signed
    function automatic logic signed [COORD_W-1:0] deflect(input longint coord,
                                                          input logic [GAIN_W-1:0] gain);
        longint scaled;
        scaled = (coord * longint'({1'b0, gain})) >>> FRAC_BITS;
        if (scaled > 32767) begin
            scaled = 32767;
        end else if (scaled < -32768) begin
            scaled = -32768;
        end
        return scaled[COORD_W-1:0];
    endfunction

    task automatic queue_segment_samples(input logic signed [COORD_W-1:0] sx,
                                         input logic signed [COORD_W-1:0] sy,
                                         input logic signed [COORD_W-1:0] ex,
                                         input logic signed [COORD_W-1:0] ey);
        longint  count;
        t_sample smp;
        count = longint'(cfg_count);
        if (count < 1) begin
            count = 1;
        end
        if (count > MAX_SAMPLES) begin
            count = MAX_SAMPLES;
        end
        for (longint i = 0; i < count; i++) begin
            smp.x    = deflect(lerp(sx, ex, i, count), cfg_x_gain);
            smp.y    = deflect(lerp(sy, ey, i, count), cfg_y_gain);
            smp.last = (i == count - 1);
            sample_q.push_back(smp);
        end
    endtask

    always @(posedge i_clk) begin
        t_sample want;
        t_sample got;
        if (!i_rst_n) begin
            cfg_count  = RST_SAMPLES;
            cfg_x_gain = RST_X_GAIN;
            cfg_y_gain = RST_Y_GAIN;
            sample_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SAMPLES: cfg_count  = i_cfg_data[CNT_W-1:0];
                    CFG_X_GAIN:  cfg_x_gain = i_cfg_data;
                    CFG_Y_GAIN:  cfg_y_gain = i_cfg_data;
                    default: ;
                endcase
            end
            if (seg_mon.valid && seg_mon.ready) begin
                queue_segment_samples(seg_mon.start_x, seg_mon.start_y,
                                      seg_mon.end_x, seg_mon.end_y);
            end
            if (smp_mon.valid && smp_mon.ready) begin
                got.x    = smp_mon.defl_x;
                got.y    = smp_mon.defl_y;
                got.last = smp_mon.last;
                if (sample_q.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10) begin
                        $display("unexpected sample x=%0d y=%0d last=%0b", got.x, got.y,
                                 got.last);
                    end
                end else begin
                    want = sample_q.pop_front();
                    if (got !== want) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10) begin
                            $display({"sample mismatch: expected x=%0d y=%0d last=%0b,",
                                      " got x=%0d y=%0d last=%0b"},
                                     want.x, want.y, want.last, got.x, got.y, got.last);
                        end
                    end
                end
            end
            o_pending <= sample_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
    import xvls_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 300000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [GAIN_W-1:0]    cfg_data;
    int                   chk_fail;
    int                   chk_pending;
    int                   cycle_cnt;
    int                   burst_left;

    xvls_in_if  seg_bus ();
    xvls_out_if smp_bus ();

    xy_vector_line_sampler_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (seg_bus),
        .o_out      (smp_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    xvls_sample_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .seg_mon      (seg_bus),
        .smp_mon      (smp_bus),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (chk_fail),
        .o_pending    (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial cycle_cnt = 0;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // sample sink back-pressure
    initial begin
        int mode;
        int mode_left;
        int phase;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        smp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left = mode_left - 1;
            phase     = phase + 1;
            case (mode)
                0: smp_bus.ready <= 1'b1;
                1: smp_bus.ready <= ($urandom_range(0, 3) != 0);
                2: smp_bus.ready <= ((phase % 7) < 4);
                default: smp_bus.ready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [GAIN_W-1:0] count_word,
                                input logic [GAIN_W-1:0] x_gain,
                                input logic [GAIN_W-1:0] y_gain, input bit stray);
        cfg_write(CFG_SAMPLES, count_word);
        if (stray) begin
            cfg_write(CFG_UNUSED, GAIN_W'($urandom));
        end
        cfg_write(CFG_X_GAIN, x_gain);
        cfg_write(CFG_Y_GAIN, y_gain);
        cfg_we <= 1'b0;
    endtask

    task automatic send_seg(input logic signed [COORD_W-1:0] sx,
                            input logic signed [COORD_W-1:0] sy,
                            input logic signed [COORD_W-1:0] ex,
                            input logic signed [COORD_W-1:0] ey);
        if (burst_left == 0) begin
            seg_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20)
                                                     : $urandom_range(1, 4);
        end
        seg_bus.valid   <= 1'b1;
        seg_bus.start_x <= sx;
        seg_bus.start_y <= sy;
        seg_bus.end_x   <= ex;
        seg_bus.end_y   <= ey;
        @(posedge i_clk);
        while (!seg_bus.ready) @(posedge i_clk);
        burst_left = burst_left - 1;
    endtask

    task automatic drain();
        seg_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 11))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return -16'sd1;
            4:       return 16'sd1;
            5:       return 16'sh4000;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_count_word();
        logic [CNT_W-1:0] count;
        case ($urandom_range(0, 9))
            6:       count = CNT_W'(MAX_SAMPLES);
            7:       count = '0;
            8:       count = CNT_W'($urandom_range(MAX_SAMPLES + 1, 127));
            9:       count = CNT_W'($urandom_range(16, MAX_SAMPLES - 1));
            default: count = CNT_W'($urandom_range(1, 8));
        endcase
        // upper bits are outside the register and must be dropped
        return {(GAIN_W - CNT_W)'($urandom), count};
    endfunction

    initial begin
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= '0;
        cfg_data        <= '0;
        seg_bus.valid   <= 1'b0;
        seg_bus.start_x <= '0;
        seg_bus.start_y <= '0;
        seg_bus.end_x   <= '0;
        seg_bus.end_y   <= '0;
        burst_left = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings
        send_seg(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_seg(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        send_seg(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_seg(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        send_seg(16'sd1, -16'sd1, -16'sd1, 16'sd1);
        drain();

        // zero count acts as one, full gains saturate
        apply_config(15'd0, 15'h7fff, 15'h7fff, 1'b0);
        send_seg(16'sh7fff, 16'sh8000, 16'sd0, 16'sd0);
        send_seg(16'sh8000, 16'sh7fff, 16'sd0, 16'sd0);
        send_seg(16'sh4000, -16'sh4000, 16'sd1, 16'sd1);
        drain();

        // count above max clamps, stray register write ignored
        apply_config(15'd127, 15'd0, 15'd1, 1'b1);
        send_seg(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        send_seg(16'sd0, 16'sd0, -16'sd1, -16'sd1);
        drain();

        apply_config(15'h7f85, 15'h7fff, 15'd0, 1'b0);
        send_seg(16'sh8000, -16'sd1, 16'sh7fff, 16'sd1);
        drain();

        apply_config(15'd64, 15'd1, 15'h7fff, 1'b0);
        send_seg(-16'sd1, -16'sd1, 16'sd1, 16'sd1);
        send_seg(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        drain();

        apply_config(15'd1, 15'd16384, 15'd16384, 1'b0);
        send_seg(16'sd12345, -16'sd12345, 16'sd0, 16'sd0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            apply_config(pick_count_word(), pick_gain(), pick_gain(), $urandom_range(0, 3) == 0);
            for (int k = 0; k < 12; k++) begin
                send_seg(pick_coord(), pick_coord(), pick_coord(), pick_coord());
            end
            drain();
        end

        repeat (30) @(posedge i_clk);
        if (chk_fail == 0 && chk_pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
